>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the indexed list unit.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ILR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed list unit: assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ILR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed list unit: assertion failed");

`endif

>>> hw/rtl/ilr_pkg.sv
// Types and codes of the indexed list unit.
// No dependencies; used by ilr_cell and indexed_list_insert_remove_unit.
package ilr_pkg;

    // Command codes carried by the cmd port.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_SET    = 2'd3
    } cmd_t;

    // Status codes reported with every result.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // What every cell does with its entry on a clock edge.
    typedef enum logic [1:0] {
        MODE_HOLD   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_WRITE  = 2'd3
    } mode_t;

    // Control broadcast along the chain of cells.
    typedef struct packed {
        logic  en;
        mode_t mode;
    } cell_ctl_t;

endpackage

>>> hw/rtl/indexed_list_insert_remove_unit.sv
// Top level of the indexed list unit: command decode, cell chain, read tree.
// Depends on ilr_pkg, ilr_cell and assert_macros.svh.
//
// A bounded ordered list of DEPTH words kept in a chain of cells, one entry
// per cell. A command beat is taken when start is high and busy is low; the
// whole chain shifts in that same edge, so insert and remove cost no more than
// get or set. A command passes the group registers, then the result register:
// the cell taps are folded into group registers of eight in the accept cycle,
// and the final OR across the groups then sets the result register. busy is
// high in between. The result beat shows on word_out, count and status for
// exactly one cycle, marked by done; the receiver cannot stall it. A new
// command may be started in the cycle that done is high.
`include "assert_macros.svh"

module indexed_list_insert_remove_unit
    import ilr_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     cmd,
    input  logic [$clog2(DEPTH+1)-1:0]     position,
    input  logic [WORD_BITS-1:0]           word_in,
    output logic                           done,
    output logic [WORD_BITS-1:0]           word_out,
    output logic [$clog2(DEPTH+1)-1:0]     count,
    output logic [1:0]                     status
);

    localparam int CB    = $clog2(DEPTH + 1);
    localparam int GS    = 8;
    localparam int NG    = (DEPTH + GS - 1) / GS;

    logic                 accept;
    cmd_t                 cmd_c;
    cell_ctl_t            ctl;
    mode_t                mode_c;
    status_t              st_c;
    logic                 rd_c;
    logic [CB-1:0]        filled_next;

    logic [CB-1:0]        filled_reg;
    logic                 pend_reg;
    logic                 rd_reg;
    status_t              st_pend_reg;
    logic                 done_reg;
    logic [WORD_BITS-1:0] word_out_reg;
    status_t              status_reg;

    logic [WORD_BITS-1:0] cell_q   [DEPTH];
    logic [WORD_BITS-1:0] cell_tap [DEPTH];
    logic [WORD_BITS-1:0] grp_c    [NG];
    logic [WORD_BITS-1:0] grp_reg  [NG];
    logic [WORD_BITS-1:0] tree_or;

    assign accept = start && !pend_reg;
    assign cmd_c  = cmd_t'(cmd);

    // Command decode: range checks against the fill count.
    always_comb
    begin
        st_c        = ST_OK;
        mode_c      = MODE_HOLD;
        rd_c        = 1'b0;
        filled_next = filled_reg;
        case (cmd_c)
            CMD_INSERT:
            begin
                if (position > filled_reg)
                begin
                    st_c = ST_RANGE;
                end
                else if (filled_reg == CB'(DEPTH))
                begin
                    st_c = ST_FULL;
                end
                else
                begin
                    mode_c      = MODE_INSERT;
                    filled_next = filled_reg + CB'(1);
                end
            end
            CMD_REMOVE:
            begin
                if (filled_reg == '0)
                begin
                    st_c = ST_EMPTY;
                end
                else if (position >= filled_reg)
                begin
                    st_c = ST_RANGE;
                end
                else
                begin
                    mode_c      = MODE_REMOVE;
                    rd_c        = 1'b1;
                    filled_next = filled_reg - CB'(1);
                end
            end
            CMD_GET:
            begin
                if (position >= filled_reg)
                begin
                    st_c = ST_RANGE;
                end
                else
                begin
                    rd_c = 1'b1;
                end
            end
            CMD_SET:
            begin
                if (position < filled_reg)
                begin
                    mode_c = MODE_WRITE;
                    rd_c   = 1'b1;
                end
                else if (position == filled_reg)
                begin
                    if (filled_reg == CB'(DEPTH))
                    begin
                        st_c = ST_FULL;
                    end
                    else
                    begin
                        mode_c      = MODE_WRITE;
                        filled_next = filled_reg + CB'(1);
                    end
                end
                else
                begin
                    st_c = ST_RANGE;
                end
            end
            default:
            begin
                st_c = ST_OK;
            end
        endcase
    end

    assign ctl.en   = accept;
    assign ctl.mode = mode_c;

    // The chain of cells, each wired to its two neighbors.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_q[i+1];
        end

        ilr_cell #(
            .WORD_BITS (WORD_BITS),
            .POS_BITS  (CB),
            .INDEX     (i)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .pos     (position),
            .word_in (word_in),
            .left_q  (left_w),
            .right_q (right_w),
            .q       (cell_q[i]),
            .tap     (cell_tap[i])
        );
    end

    // First level of the read tree: OR of eight cell taps per group.
    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        always_comb
        begin
            grp_c[g] = '0;
            for (int k = 0; k < GS; k++)
            begin
                if (g * GS + k < DEPTH)
                begin
                    grp_c[g] = grp_c[g] | cell_tap[g * GS + k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                grp_reg[g] <= grp_c[g];
            end
        end
    end

    // Second level of the read tree across the group registers.
    always_comb
    begin
        tree_or = '0;
        for (int g = 0; g < NG; g++)
        begin
            tree_or = tree_or | grp_reg[g];
        end
    end

    // Fill count and the pending command's status and read flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg  <= '0;
            pend_reg    <= 1'b0;
            rd_reg      <= 1'b0;
            st_pend_reg <= ST_OK;
        end
        else if (accept)
        begin
            filled_reg  <= filled_next;
            pend_reg    <= 1'b1;
            rd_reg      <= rd_c;
            st_pend_reg <= st_c;
        end
        else
        begin
            pend_reg <= 1'b0;
        end
    end

    // Result beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            done_reg   <= pend_reg;
            status_reg <= st_pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            word_out_reg <= rd_reg ? tree_or : '0;
        end
    end

    assign busy     = pend_reg;
    assign done     = done_reg;
    assign word_out = word_out_reg;
    assign count    = filled_reg;
    assign status   = status_reg;

    // A taken beat is worked on while busy is high, then its result shows.
    `ILR_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy && !done)
    `ILR_ASSERT_NXT(a_busy_done, clk, rst_n, busy, done && !busy)
    // Failed commands return no data.
    `ILR_ASSERT_IMP(a_fail_zero, clk, rst_n, done && (status != ST_OK), word_out == '0)
    // The list never holds more than its capacity.
    `ILR_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count <= CB'(DEPTH))
    // The count moves only when a command is taken.
    `ILR_ASSERT_NXT(a_count_hold, clk, rst_n, !accept, $stable(count))

endmodule

>>> hw/rtl/ilr_cell.sv
// One storage cell of the list chain: holds the entry at a fixed index.
// Depends on ilr_pkg for the broadcast control struct.
module ilr_cell
    import ilr_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int POS_BITS  = 7,
    parameter int INDEX     = 0
) (
    input  logic                 clk,
    input  cell_ctl_t            ctl,
    input  logic [POS_BITS-1:0]  pos,
    input  logic [WORD_BITS-1:0] word_in,
    input  logic [WORD_BITS-1:0] left_q,
    input  logic [WORD_BITS-1:0] right_q,
    output logic [WORD_BITS-1:0] q,
    output logic [WORD_BITS-1:0] tap
);

    logic [WORD_BITS-1:0] q_reg;
    logic [WORD_BITS-1:0] q_next;
    logic                 hit;
    logic                 above;

    // Where this cell sits relative to the addressed index.
    assign hit   = (pos == POS_BITS'(INDEX));
    assign above = (POS_BITS'(INDEX) > pos);

    // Insert takes the lower neighbor, remove the upper one.
    always_comb
    begin
        q_next = q_reg;
        if (ctl.en)
        begin
            case (ctl.mode)
                MODE_INSERT:
                begin
                    if (above)
                    begin
                        q_next = left_q;
                    end
                    else if (hit)
                    begin
                        q_next = word_in;
                    end
                end
                MODE_REMOVE:
                begin
                    if (hit || above)
                    begin
                        q_next = right_q;
                    end
                end
                MODE_WRITE:
                begin
                    if (hit)
                    begin
                        q_next = word_in;
                    end
                end
                default:
                begin
                    q_next = q_reg;
                end
            endcase
        end
    end

    // The entry itself needs no reset.
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    // The addressed cell offers its old entry for the read path.
    assign q   = q_reg;
    assign tap = hit ? q_reg : '0;

endmodule

>>> dv/tb_indexed_list_insert_remove_unit.sv
// Self-checking testbench for indexed_list_insert_remove_unit.
// Depends on ilr_pkg and the RTL of the unit. A directed table is followed by
// random command streams that are checked against a local list predictor.
`timescale 1ns / 100ps

module tb_indexed_list_insert_remove_unit;
    import ilr_pkg::*;

    localparam int DEPTH      = 64;
    localparam int WORD_BITS  = 32;
    localparam int POS_BITS   = $clog2(DEPTH + 1);
    localparam int NUM_RANDOM = 450;
    localparam int IDLE_LIMIT = 1000;
    localparam int NUM_ROWS   = 24;

    // One result beat: the returned word, the entry count and the status.
    typedef struct packed {
        logic [WORD_BITS-1:0] data;
        logic [POS_BITS-1:0]  cnt;
        status_t              st;
    } list_result_t;

    // One row of the directed table; exp is used only when known is set.
    typedef struct packed {
        cmd_t                 op;
        logic [POS_BITS-1:0]  pos;
        logic [WORD_BITS-1:0] data;
        logic                 known;
        list_result_t         exp;
    } stim_row_t;

    // Random traffic modes: grow toward full, shrink toward empty.
    typedef enum logic [1:0] {
        FILL_UP,
        HOLD_FULL,
        DRAIN,
        HOLD_EMPTY
    } traffic_mode_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 start    = 1'b0;
    logic [1:0]           cmd      = CMD_INSERT;
    logic [POS_BITS-1:0]  position = '0;
    logic [WORD_BITS-1:0] word_in  = '0;
    logic                 busy;
    logic                 done;
    logic [WORD_BITS-1:0] word_out;
    logic [POS_BITS-1:0]  count;
    logic [1:0]           status;

    // Fixed expectation for the beat being offered, from the directed table.
    logic                 beat_known = 1'b0;
    list_result_t         beat_exp   = '0;

    // Predictor state: the list contents and its length.
    logic [WORD_BITS-1:0] list_words [DEPTH];
    int                   list_len = 0;

    list_result_t         pending_results [$];
    int                   error_count = 0;
    int                   idle_cycles = 0;
    int                   quiet_left  = 0;

    stim_row_t directed_rows [0:NUM_ROWS-1] = '{
        '{CMD_GET,    7'd0,   32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd0, ST_RANGE}},
        '{CMD_REMOVE, 7'd0,   32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd0, ST_EMPTY}},
        '{CMD_INSERT, 7'd1,   32'hDEAD_BEEF, 1'b1, '{32'h0000_0000, 7'd0, ST_RANGE}},
        '{CMD_SET,    7'd1,   32'hDEAD_BEEF, 1'b1, '{32'h0000_0000, 7'd0, ST_RANGE}},
        '{CMD_GET,    7'd127, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 7'd0, ST_RANGE}},
        '{CMD_INSERT, 7'd0,   32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 7'd1, ST_OK}},
        '{CMD_INSERT, 7'd0,   32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd2, ST_OK}},
        '{CMD_SET,    7'd2,   32'h1234_5678, 1'b1, '{32'h0000_0000, 7'd3, ST_OK}},
        '{CMD_GET,    7'd0,   32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 7'd3, ST_OK}},
        '{CMD_GET,    7'd1,   32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 7'd3, ST_OK}},
        '{CMD_GET,    7'd3,   32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd3, ST_RANGE}},
        '{CMD_SET,    7'd1,   32'hA5A5_A5A5, 1'b1, '{32'hFFFF_FFFF, 7'd3, ST_OK}},
        '{CMD_SET,    7'd4,   32'h0000_0001, 1'b1, '{32'h0000_0000, 7'd3, ST_RANGE}},
        '{CMD_REMOVE, 7'd2,   32'h0000_0000, 1'b1, '{32'h1234_5678, 7'd2, ST_OK}},
        '{CMD_REMOVE, 7'd2,   32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd2, ST_RANGE}},
        '{CMD_INSERT, 7'd1,   32'h5A5A_5A5A, 1'b0, '0},
        '{CMD_INSERT, 7'd3,   32'hC3C3_C3C3, 1'b0, '0},
        '{CMD_REMOVE, 7'd0,   32'h0000_0000, 1'b0, '0},
        '{CMD_INSERT, 7'd127, 32'h8000_0000, 1'b1, '{32'h0000_0000, 7'd3, ST_RANGE}},
        '{CMD_REMOVE, 7'd127, 32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd3, ST_RANGE}},
        '{CMD_SET,    7'd127, 32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, 7'd3, ST_RANGE}},
        '{CMD_GET,    7'd64,  32'h0000_0000, 1'b1, '{32'h0000_0000, 7'd3, ST_RANGE}},
        '{CMD_SET,    7'd3,   32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_REMOVE, 7'd3,   32'h0000_0000, 1'b0, '0}
    };

    indexed_list_insert_remove_unit #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .position (position),
        .word_in  (word_in),
        .done     (done),
        .word_out (word_out),
        .count    (count),
        .status   (status)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one command to the list predictor and returns the result it gives.
    task automatic apply_list_cmd(input cmd_t op, input logic [POS_BITS-1:0] p,
                                  input logic [WORD_BITS-1:0] w,
                                  output list_result_t r);
        int i;
        r.data = '0;
        r.st   = ST_OK;
        case (op)
            CMD_INSERT:
            begin
                if (p > list_len)
                    r.st = ST_RANGE;
                else if (list_len >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    for (i = list_len; i > p; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[p] = w;
                    list_len++;
                end
            end
            CMD_REMOVE:
            begin
                if (list_len == 0)
                    r.st = ST_EMPTY;
                else if (p >= list_len)
                    r.st = ST_RANGE;
                else
                begin
                    r.data = list_words[p];
                    for (i = p; i + 1 < list_len; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            CMD_GET:
            begin
                if (p >= list_len)
                    r.st = ST_RANGE;
                else
                    r.data = list_words[p];
            end
            default:
            begin
                // Set overwrites inside the list and appends at its end.
                if (p < list_len)
                begin
                    r.data = list_words[p];
                    list_words[p] = w;
                end
                else if (p == list_len)
                begin
                    if (list_len >= DEPTH)
                        r.st = ST_FULL;
                    else
                    begin
                        list_words[list_len] = w;
                        list_len++;
                    end
                end
                else
                    r.st = ST_RANGE;
            end
        endcase
        r.cnt = POS_BITS'(list_len);
    endtask

    // Offers one command beat and holds it until the unit takes it.
    task automatic issue_cmd(input cmd_t op, input logic [POS_BITS-1:0] p,
                             input logic [WORD_BITS-1:0] w, input logic known,
                             input list_result_t exp);
        start      <= 1'b1;
        cmd        <= op;
        position   <= p;
        word_in    <= w;
        beat_known <= known;
        beat_exp   <= exp;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    // Idle gap after a beat: mostly short, a few long, with runs of no gaps.
    function automatic int pick_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Lowers start for a number of cycles, with junk on the command ports.
    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            start    <= 1'b0;
            cmd      <= 2'($urandom_range(0, 3));
            position <= POS_BITS'($urandom_range(0, 127));
            word_in  <= $urandom;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Random data word, with the all-zero and all-one patterns now and then.
    function automatic logic [WORD_BITS-1:0] pick_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // Result checker: compares each result beat with the oldest prediction,
    // then records the prediction for a command beat taken at this edge.
    always @(posedge clk)
    begin : result_check
        list_result_t want;
        list_result_t pred;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (word_out !== want.data)
                    begin
                        $error("word_out: expected %h, got %h", want.data, word_out);
                        error_count++;
                    end
                    if (count !== want.cnt)
                    begin
                        $error("count: expected %0d, got %0d", want.cnt, count);
                        error_count++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        error_count++;
                    end
                end
            end
            if (start && busy === 1'b0)
            begin
                apply_list_cmd(cmd_t'(cmd), position, word_in, pred);
                pending_results.push_back(beat_known ? beat_exp : pred);
            end
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_indexed_list_insert_remove_unit NOT OK");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random traffic.
    initial
    begin
        traffic_mode_t        mode;
        int                   hold_left;
        int                   n;
        int                   r;
        cmd_t                 op;
        logic [POS_BITS-1:0]  p;
        for (n = 0; n < DEPTH; n++)
            list_words[n] = '0;
        mode      = FILL_UP;
        hold_left = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table.
        for (n = 0; n < NUM_ROWS; n++)
        begin
            issue_cmd(directed_rows[n].op, directed_rows[n].pos, directed_rows[n].data,
                      directed_rows[n].known, directed_rows[n].exp);
            idle_sender(pick_gap());
        end
        drain_results();

        // Random traffic, alternating between filling and draining the list.
        for (n = 0; n < NUM_RANDOM; n++)
        begin
            case (mode)
                FILL_UP:
                    if (list_len == DEPTH)
                    begin
                        mode      = HOLD_FULL;
                        hold_left = $urandom_range(8, 20);
                    end
                HOLD_FULL:
                    if (hold_left == 0)
                        mode = DRAIN;
                    else
                        hold_left--;
                DRAIN:
                    if (list_len == 0)
                    begin
                        mode      = HOLD_EMPTY;
                        hold_left = $urandom_range(3, 8);
                    end
                default:
                    if (hold_left == 0)
                        mode = FILL_UP;
                    else
                        hold_left--;
            endcase

            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                // Noise: any command at any position.
                op = cmd_t'($urandom_range(0, 3));
                p  = POS_BITS'($urandom_range(0, 127));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (mode == FILL_UP || mode == HOLD_FULL)
                    op = (r < 45) ? CMD_INSERT : (r < 75) ? CMD_SET :
                         (r < 90) ? CMD_GET : CMD_REMOVE;
                else
                    op = (r < 55) ? CMD_REMOVE : (r < 70) ? CMD_INSERT :
                         (r < 85) ? CMD_SET : CMD_GET;
                case (op)
                    CMD_INSERT:
                        p = POS_BITS'($urandom_range(0, list_len));
                    CMD_SET:
                        if ($urandom_range(0, 9) < 7)
                            p = POS_BITS'(list_len);
                        else
                            p = POS_BITS'($urandom_range(0, list_len));
                    default:
                        p = POS_BITS'((list_len == 0) ? 0 : $urandom_range(0, list_len - 1));
                endcase
            end

            issue_cmd(op, p, pick_word(), 1'b0, '0);
            if (n % 100 == 99)
                drain_results();
            else
                idle_sender(pick_gap());
        end

        // Wait out the last results and the pipeline behind them.
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (error_count == 0)
            $display("tb_indexed_list_insert_remove_unit OK");
        else
            $display("tb_indexed_list_insert_remove_unit NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ilr_pkg.sv
hw/rtl/ilr_cell.sv
hw/rtl/indexed_list_insert_remove_unit.sv
dv/tb_indexed_list_insert_remove_unit.sv
